FILE: hdl/dnsar_pkg.sv
// ----------------------------------------------------------------------------
// dnsar_pkg
// Shared types, codes and constants for the fixed A-record DNS responder.
// ----------------------------------------------------------------------------
package dnsar_pkg;

    // One query byte as it arrives on the request channel.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } dnsar_in_t;

    // One response result: a data byte or the end-of-packet verdict.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_verdict;
        logic [2:0] verdict_code;
        logic       run_last;
    } dnsar_out_t;

    // Work left for the emitter from one accepted request.
    typedef struct packed {
        logic       data_pend;
        logic [7:0] data_byte;
        logic       ans_pend;
        logic       verd_pend;
        logic [2:0] verd_code;
    } dnsar_job_t;

    // Verdict codes.
    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_LONG      = 3'd2;
    localparam logic [2:0] VERDICT_LABEL     = 3'd3;
    localparam logic [2:0] VERDICT_MALFORMED = 3'd4;
    localparam logic [2:0] VERDICT_NO_ROOM   = 3'd5;

    // Register index of answer_ip, taken from word address bit paddr[2].
    localparam logic       REG_ANSWER_IP     = 1'b0;

    // Positions in the packet and limits.
    localparam logic [10:0] HEADER_LEN  = 11'd12;
    localparam logic [10:0] POS_NEVER   = 11'd1026;
    localparam logic [9:0]  COUNT_MAX   = 10'd1023;
    localparam logic [7:0]  LABEL_MAX   = 8'd63;
    localparam logic [11:0] ANSWER_LEN  = 12'd16;
    localparam int          ANSWER_LAST = 15;

    // Answer record byte: name pointer, type A, class IN, TTL 60, length 4, address.
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] ip);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h00;
            4'd7:    b = 8'h00;
            4'd8:    b = 8'h00;
            4'd9:    b = 8'h3C;
            4'd10:   b = 8'h00;
            4'd11:   b = 8'h04;
            4'd12:   b = ip[31:24];
            4'd13:   b = ip[23:16];
            4'd14:   b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/dnsar_parser.sv
// ----------------------------------------------------------------------------
// dnsar_parser
// Per-packet parse state. Turns each accepted query byte into an emitter job.
// ----------------------------------------------------------------------------
module dnsar_parser #(
    parameter int MAX_PACKET = 512
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  dnsar_pkg::dnsar_in_t in_data,
    output dnsar_pkg::dnsar_job_t job
);
    import dnsar_pkg::*;

    localparam logic [11:0] MAX_P = 12'(MAX_PACKET);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_NAME   = 2'd1;
    localparam logic [1:0] PH_TAIL   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [9:0]  byte_count_reg, byte_count_next;
    logic        past_end_reg, past_end_next;
    logic [10:0] next_label_reg, next_label_next;
    logic [1:0]  phase_reg, phase_next;
    logic [10:0] qend_reg, qend_next;
    logic        label_err_reg, label_err_next;
    logic        room_err_reg, room_err_next;

    logic [10:0] pos;
    logic [10:0] len;
    logic [10:0] qe_sum;
    logic [10:0] lbl_sum;
    logic [11:0] room_sum;
    logic [7:0]  b;

    assign b        = in_data.in_byte;
    assign pos      = {1'b0, byte_count_reg} + {10'd0, past_end_reg};
    assign len      = pos + 11'd1;
    assign qe_sum   = pos + 11'd5;
    assign lbl_sum  = pos + {3'd0, b} + 11'd1;
    assign room_sum = {1'b0, qend_reg} + ANSWER_LEN;

    // Next parse state and the job for this byte.
    always_comb begin
        byte_count_next = byte_count_reg;
        past_end_next   = past_end_reg;
        next_label_next = next_label_reg;
        phase_next      = phase_reg;
        qend_next       = qend_reg;
        label_err_next  = label_err_reg;
        room_err_next   = room_err_reg;
        job             = '0;

        if (byte_count_reg == COUNT_MAX) begin
            past_end_next = 1'b1;
        end else begin
            byte_count_next = byte_count_reg + 10'd1;
        end

        unique case (phase_reg)
            PH_HEADER: begin
                // Header rewrite: QR set, RCODE cleared, ANCOUNT, NSCOUNT and ARCOUNT forced.
                job.data_pend = 1'b1;
                priority if (pos == 11'd2) begin
                    job.data_byte = b | 8'h80;
                end else if (pos == 11'd3) begin
                    job.data_byte = b & 8'hF0;
                end else if (pos == 11'd6) begin
                    job.data_byte = 8'h00;
                end else if (pos == 11'd7) begin
                    job.data_byte = 8'h01;
                end else if (pos >= 11'd8) begin
                    job.data_byte = 8'h00;
                end else begin
                    job.data_byte = b;
                end
                if (pos >= 11'd11) begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME: begin
                // Walk the question name by its label length bytes.
                job.data_pend = 1'b1;
                job.data_byte = b;
                if (pos == next_label_reg) begin
                    priority if (b == 8'd0) begin
                        qend_next  = (qe_sum > 11'd1025) ? POS_NEVER : qe_sum;
                        phase_next = PH_TAIL;
                    end else if (b > LABEL_MAX) begin
                        label_err_next = 1'b1;
                        phase_next     = PH_DONE;
                    end else begin
                        next_label_next = (lbl_sum > 11'd1024) ? POS_NEVER : lbl_sum;
                    end
                end
            end
            PH_TAIL: begin
                // QTYPE and QCLASS pass; the answer follows the last QCLASS byte if it fits.
                job.data_pend = 1'b1;
                job.data_byte = b;
                if (len == qend_reg) begin
                    phase_next = PH_DONE;
                    if (room_sum > MAX_P) begin
                        room_err_next = 1'b1;
                    end else begin
                        job.ans_pend = 1'b1;
                    end
                end
            end
            default: begin
                // Bytes after the question or a bad label are dropped.
            end
        endcase

        // End-of-packet verdict.
        if (in_data.in_last) begin
            job.verd_pend = 1'b1;
            priority if (len < HEADER_LEN) begin
                job.verd_code = VERDICT_SHORT;
            end else if ({1'b0, len} > MAX_P) begin
                job.verd_code = VERDICT_LONG;
            end else if (label_err_next) begin
                job.verd_code = VERDICT_LABEL;
            end else if (phase_next != PH_DONE || qend_next == 11'd0) begin
                job.verd_code = VERDICT_MALFORMED;
            end else if (room_err_next) begin
                job.verd_code = VERDICT_NO_ROOM;
            end else begin
                job.verd_code = VERDICT_OK;
            end
            byte_count_next = '0;
            past_end_next   = 1'b0;
            next_label_next = HEADER_LEN;
            phase_next      = PH_HEADER;
            qend_next       = '0;
            label_err_next  = 1'b0;
            room_err_next   = 1'b0;
        end
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            past_end_reg   <= 1'b0;
            next_label_reg <= HEADER_LEN;
            phase_reg      <= PH_HEADER;
            qend_reg       <= '0;
            label_err_reg  <= 1'b0;
            room_err_reg   <= 1'b0;
        end else if (accept) begin
            byte_count_reg <= byte_count_next;
            past_end_reg   <= past_end_next;
            next_label_reg <= next_label_next;
            phase_reg      <= phase_next;
            qend_reg       <= qend_next;
            label_err_reg  <= label_err_next;
            room_err_reg   <= room_err_next;
        end
    end

endmodule

FILE: hdl/dnsar_emitter.sv
// ----------------------------------------------------------------------------
// dnsar_emitter
// Holds one job and plays out its results into the output register.
// ----------------------------------------------------------------------------
module dnsar_emitter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dnsar_pkg::dnsar_job_t job_in,
    input  logic [31:0]           answer_ip,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dnsar_pkg::dnsar_out_t m_data
);
    import dnsar_pkg::*;

    dnsar_job_t job_reg, job_next;
    logic [3:0] ans_idx_reg, ans_idx_next;
    logic       m_valid_reg, m_valid_next;
    dnsar_out_t m_data_reg, m_data_next;

    logic       job_any;
    logic       out_load;
    logic       emit;
    logic       item_last;
    dnsar_out_t item;

    assign job_any  = job_reg.data_pend | job_reg.ans_pend | job_reg.verd_pend;
    assign out_load = !m_valid_reg || m_ready;
    assign emit     = job_any && out_load;

    // Pick the next result of the held job: data byte, answer bytes, verdict.
    always_comb begin
        item      = '0;
        item_last = 1'b0;
        priority if (job_reg.data_pend) begin
            item.out_byte = job_reg.data_byte;
            item_last     = !job_reg.ans_pend && !job_reg.verd_pend;
        end else if (job_reg.ans_pend) begin
            item.out_byte = answer_byte(ans_idx_reg, answer_ip);
            item_last     = (ans_idx_reg == 4'(ANSWER_LAST)) && !job_reg.verd_pend;
        end else begin
            item.is_verdict   = 1'b1;
            item.verdict_code = job_reg.verd_code;
            item_last         = 1'b1;
        end
        item.run_last = item_last;
    end

    // A new request enters when the held job is gone or leaves this cycle.
    assign s_ready = !job_any || (emit && item_last);

    // Job and output register updates.
    always_comb begin
        job_next     = job_reg;
        ans_idx_next = ans_idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = item;
            priority if (job_reg.data_pend) begin
                job_next.data_pend = 1'b0;
            end else if (job_reg.ans_pend) begin
                ans_idx_next = ans_idx_reg + 4'd1;
                if (ans_idx_reg == 4'(ANSWER_LAST)) begin
                    job_next.ans_pend = 1'b0;
                end
            end else begin
                job_next.verd_pend = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_valid && s_ready) begin
            job_next     = job_in;
            ans_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg     <= '0;
            ans_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            job_reg     <= job_next;
            ans_idx_reg <= ans_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/dns_fixed_a_record_responder_top.sv
// ----------------------------------------------------------------------------
// dns_fixed_a_record_responder_top
// DNS query in, fixed A-record response and verdict out, one byte a request.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries query bytes (s_data.in_byte) with s_data.in_last on
// the final byte. The m_ channel returns response bytes and, after the last
// byte of each packet, one verdict result (is_verdict set, code in
// verdict_code). run_last marks the last result caused by each request.
// A nonzero verdict means the response must be discarded. A request passes
// the job register, then the output register. Throughput is one request per
// cycle while m_ready is high; a request that completes the question holds
// s_ready low while it plays out the 16-byte answer record, and a final byte
// holds it for its verdict. answer_ip sits behind an APB port at address 0;
// the user must write it only while the block is idle, which the block never
// checks. Reset clears the parse state, drops any held results and sets
// answer_ip to 192.168.1.1. When m_ready is low the output register holds
// its result; one more request is still taken into the job register.
// ----------------------------------------------------------------------------
module dns_fixed_a_record_responder_top #(
    parameter int MAX_PACKET = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dnsar_pkg::dnsar_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dnsar_pkg::dnsar_out_t m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import dnsar_pkg::*;

    localparam logic [31:0] ANSWER_IP_RESET = 32'hC0A8_0101;

    logic [31:0] answer_ip_reg;
    logic        accept;
    dnsar_job_t  job;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answer_ip_reg <= ANSWER_IP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ANSWER_IP) begin
            answer_ip_reg <= pwdata;
        end
    end
    assign prdata = (paddr[2] == REG_ANSWER_IP) ? answer_ip_reg : 32'd0;

    assign accept = s_valid && s_ready;

    dnsar_parser #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .job     (job)
    );

    dnsar_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .job_in    (job),
        .answer_ip (answer_ip_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
